FILE: design/multi_gate_crossing_timer_core_defines.svh
// Assertion macros shared by the multi-gate crossing timer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MULTI_GATE_CROSSING_TIMER_CORE_DEFINES_SVH
`define MULTI_GATE_CROSSING_TIMER_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define MGCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define MGCT_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (prop)) else $error(msg);

`endif

FILE: design/mgct_pkg.sv
// Types and constants of the multi-gate crossing timer.
// No dependencies; imported by every module of the block.
package mgct_pkg;

    localparam int GATE_COUNT    = 11;
    localparam int GIDX_W        = 4;
    localparam int TIME_W        = 17;
    localparam int RUN_W         = 8;
    localparam int TMO_W         = 16;
    localparam int CFG_AW        = 3;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [0:0]       REG_TIMEOUT   = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ARMED   = 2'd1,
        PH_RUNNING = 2'd2
    } t_phase;

    typedef struct packed {
        logic                  start_req;
        logic [GATE_COUNT-1:0] gate_levels;
    } t_in_item;

    typedef struct packed {
        logic [GIDX_W-1:0] gate_index;
        logic              captured;
        logic [TIME_W-1:0] crossing_time;
        logic [RUN_W-1:0]  run_number;
        logic              last;
    } t_report;

    // Control broadcast to every gate lane.
    typedef struct packed {
        logic              sample;
        logic              clear;
        logic [TIME_W-1:0] elapsed;
    } t_lane_ctrl;

    // Run result handed to the report stage.
    typedef struct packed {
        logic                              load;
        logic [GATE_COUNT-1:0]             cap;
        logic [GATE_COUNT-1:0][TIME_W-1:0] times;
        logic [RUN_W-1:0]                  run;
    } t_snap;

endpackage

FILE: design/mgct_lane.sv
// One gate lane: capture flag and crossing time of a single gate.
// Depends on mgct_pkg.
module mgct_lane
    import mgct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctrl        i_ctrl,
    input  logic              i_level,
    output logic              o_cap_next,
    output logic [TIME_W-1:0] o_time_next
);

    logic              r_cap;
    logic [TIME_W-1:0] r_time;
    logic              hit;

    // Only the first break of the run is captured.
    assign hit         = i_ctrl.sample && i_level && !r_cap;
    assign o_cap_next  = r_cap || hit;
    assign o_time_next = hit ? i_ctrl.elapsed : r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_cap  <= 1'b0;
            r_time <= '0;
        end else begin
            r_cap  <= o_cap_next;
            r_time <= o_time_next;
        end
    end

endmodule

FILE: design/mgct_report.sv
// Report stage: takes the lanes' results at run end and shifts out one
// report per gate. Depends on mgct_pkg and the assertion macro header.
`include "multi_gate_crossing_timer_core_defines.svh"

module mgct_report
    import mgct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_snap   i_snap,
    output logic    o_valid,
    input  logic    i_ready,
    output t_report o_rpt
);

    logic                              r_busy, n_busy;
    logic [GIDX_W-1:0]                 r_idx, n_idx;
    logic [GATE_COUNT-1:0]             r_cap, n_cap;
    logic [GATE_COUNT-1:0][TIME_W-1:0] r_time, n_time;
    logic [RUN_W-1:0]                  r_run, n_run;
    logic                              xfer;
    logic                              is_last;

    assign xfer    = r_busy && i_ready;
    assign is_last = (r_idx == GIDX_W'(GATE_COUNT - 1));

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_cap  = r_cap;
        n_time = r_time;
        n_run  = r_run;
        if (i_snap.load) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_cap  = i_snap.cap;
            n_run  = i_snap.run;
            for (int g = 0; g < GATE_COUNT; g++) begin
                n_time[g] = i_snap.cap[g] ? i_snap.times[g] : '0;
            end
        end else if (xfer) begin
            // advance the shift line toward the output tap
            n_idx  = r_idx + GIDX_W'(1);
            n_busy = !is_last;
            n_cap  = {1'b0, r_cap[GATE_COUNT-1:1]};
            for (int g = 0; g < GATE_COUNT - 1; g++) begin
                n_time[g] = r_time[g+1];
            end
            n_time[GATE_COUNT-1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_cap  <= n_cap;
        r_time <= n_time;
        r_run  <= n_run;
    end

    assign o_valid             = r_busy;
    assign o_rpt.gate_index    = r_idx;
    assign o_rpt.captured      = r_cap[0];
    assign o_rpt.crossing_time = r_time[0];
    assign o_rpt.run_number    = r_run;
    assign o_rpt.last          = is_last;

    `MGCT_ASSERT(a_no_load_busy, !(r_busy && i_snap.load), "run result arrived while reports drain")
    `MGCT_ASSERT(a_idx_range, !r_busy || (r_idx < GIDX_W'(GATE_COUNT)), "report index out of range")
    `MGCT_ASSERT_NEXT(a_load_starts, i_snap.load, r_busy && (r_idx == '0), "load did not start reports")
    `MGCT_ASSERT_NEXT(a_last_ends, xfer && is_last, !r_busy, "reports continue past last gate")

endmodule

FILE: design/multi_gate_crossing_timer_core.sv
// Multi-gate crossing timer. Each input transfer is one tick carrying all
// gate levels and a start request; one tick is taken per clock cycle, all
// gates sampled at once by per-gate lanes. When a run ends (all gates
// captured, or elapsed ticks past r_timeout) the lanes' results are
// copied into the report stage and the lanes clear on that same cycle. The
// report stage then delivers one report per gate, at one report per
// cycle when the sink is ready. While those reports drain, ticks are
// still taken in idle; in armed or running phase the input stalls until
// the last report of the previous run has been transferred.
// Depends on mgct_pkg, mgct_lane and mgct_report.
module multi_gate_crossing_timer_core
    import mgct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_report           o_rpt,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_phase                            r_phase, n_phase;
    logic [TIME_W-1:0]                 r_elapsed, n_elapsed;
    logic [RUN_W-1:0]                  r_run, n_run;
    logic [TMO_W-1:0]                  r_timeout;
    logic                              in_xfer;
    logic                              busy_phase;
    logic                              any_level;
    logic                              all_cap;
    logic                              run_end;
    logic [TIME_W-1:0]                 elapsed_next;
    t_lane_ctrl                        lane_ctrl;
    t_snap                             snap;
    logic [GATE_COUNT-1:0]             cap_next;
    logic [GATE_COUNT-1:0][TIME_W-1:0] time_next;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
            r_timeout <= pwdata[TMO_W-1:0];
        end
    end

    // Input side
    assign busy_phase = (r_phase == PH_ARMED) || (r_phase == PH_RUNNING);
    assign o_in_ready = !(o_out_valid && busy_phase);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign any_level  = |i_item.gate_levels;
    assign all_cap    = &cap_next;

    // Lane control and run end
    always_comb begin
        elapsed_next     = '0;
        lane_ctrl.sample = 1'b0;
        run_end          = 1'b0;
        unique case (r_phase)
            PH_ARMED: begin
                lane_ctrl.sample = in_xfer && any_level;
                run_end          = lane_ctrl.sample && all_cap;
            end
            PH_RUNNING: begin
                elapsed_next     = r_elapsed + TIME_W'(1);
                lane_ctrl.sample = in_xfer;
                run_end          = in_xfer &&
                                   (all_cap || elapsed_next > {1'b0, r_timeout});
            end
            default: begin
            end
        endcase
        lane_ctrl.elapsed = elapsed_next;
        lane_ctrl.clear   = run_end;
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_ARMED: begin
                if (lane_ctrl.sample) begin
                    n_phase = run_end ? PH_IDLE : PH_RUNNING;
                end
            end
            PH_RUNNING: begin
                if (run_end) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                if (in_xfer) begin
                    n_phase = i_item.start_req ? PH_ARMED : PH_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_elapsed = r_elapsed;
        n_run     = r_run;
        if (lane_ctrl.sample) begin
            n_elapsed = run_end ? '0 : elapsed_next;
        end
        if (run_end) begin
            n_run = r_run + RUN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_run     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_run     <= n_run;
        end
    end

    for (genvar g = 0; g < GATE_COUNT; g++) begin : g_lane
        mgct_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (lane_ctrl),
            .i_level     (i_item.gate_levels[g]),
            .o_cap_next  (cap_next[g]),
            .o_time_next (time_next[g])
        );
    end

    assign snap.load  = run_end;
    assign snap.cap   = cap_next;
    assign snap.times = time_next;
    assign snap.run   = r_run;

    mgct_report u_report (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_snap  (snap),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rpt   (o_rpt)
    );

endmodule
